// ===== sv/ssa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Softsign activation package
// Widths, constants and the pipeline stage type shared by the softsign block.
// ----------------------------------------------------------------------------
package ssa_pkg;

  // Field widths of the streams.
  localparam int SAMPLE_W   = 16;
  localparam int RESULT_W   = 16;

  // Magnitude of a Q8.8 sample needs one more bit to hold 32768 exactly.
  localparam int MAG_W      = SAMPLE_W + 1;

  // Divisor width: the square of (256 + |x|) stays below 2^31.
  localparam int DEN_W      = 31;

  // One quotient bit is produced in each divider stage.
  localparam int DIV_STEPS  = RESULT_W;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index of derivative_mode, taken from paddr bit 2.
  localparam logic REG_IDX_MODE = 1'b0;

  // Q8.8 representation of one.
  localparam logic [MAG_W-1:0] Q_ONE_IN = MAG_W'(256);

  // Largest positive Q1.15 result.
  localparam logic [RESULT_W-1:0] RES_MAX = RESULT_W'(32767);

  // Upper half of the derivative numerator 2^31, which seeds the remainder.
  localparam logic [DEN_W-1:0] DERIV_REM_INIT = DEN_W'(32'h0000_8000);

  // One item travelling down the divider.
  typedef struct packed {
    logic                vld;
    logic                mode;
    logic                neg;
    logic [DEN_W-1:0]    den;
    logic [DEN_W-1:0]    rem;
    logic [RESULT_W-1:0] num_lo;
    logic [RESULT_W-1:0] quo;
  } ssa_div_t;

endpackage

// ===== sv/ssa_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Softsign configuration registers
// APB-style register file holding the derivative mode select.
// ----------------------------------------------------------------------------
module ssa_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ssa_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ssa_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output logic                           mode
);

  logic mode_r;
  logic mode_nxt;
  logic wr_en;
  logic reg_idx;

  // The port never inserts wait states.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Only bit 0 of a write to the mode register is kept.
  always_comb begin
    mode_nxt = mode_r;
    if (wr_en && (reg_idx == ssa_pkg::REG_IDX_MODE)) begin
      mode_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // Read-back decode.
  always_comb begin
    unique case (reg_idx)
      ssa_pkg::REG_IDX_MODE: cfg_prdata = {{(ssa_pkg::CFG_DATA_W-1){1'b0}}, mode_r};
      default:               cfg_prdata = '0;
    endcase
  end

  assign mode = mode_r;

endmodule

// ===== sv/ssa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Softsign front end
// Two stages: magnitude and divisor, then squaring and divider set-up.
// ----------------------------------------------------------------------------
module ssa_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [ssa_pkg::SAMPLE_W-1:0] sample,
  input  logic                         mode,
  output ssa_pkg::ssa_div_t            stage_o
);

  typedef struct packed {
    logic                      vld;
    logic                      mode;
    logic                      neg;
    logic [ssa_pkg::MAG_W-1:0] mag;
    logic [ssa_pkg::MAG_W-1:0] d;
  } ssa_mag_t;

  ssa_mag_t          mag_r;
  ssa_mag_t          mag_nxt;
  ssa_pkg::ssa_div_t setup_r;
  ssa_pkg::ssa_div_t setup_nxt;

  logic [2*ssa_pkg::MAG_W-1:0] dsq;

  // Stage one: exact magnitude (32768 for the most negative sample) and 1 + |x|.
  always_comb begin
    mag_nxt.vld  = in_vld;
    mag_nxt.mode = mode;
    mag_nxt.neg  = sample[ssa_pkg::SAMPLE_W-1];
    if (sample[ssa_pkg::SAMPLE_W-1]) begin
      mag_nxt.mag = ssa_pkg::MAG_W'(0) - {sample[ssa_pkg::SAMPLE_W-1], sample};
    end else begin
      mag_nxt.mag = {1'b0, sample};
    end
    mag_nxt.d = mag_nxt.mag + ssa_pkg::Q_ONE_IN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r.vld <= 1'b0;
    end else if (adv) begin
      mag_r <= mag_nxt;
    end
  end

  // Stage two: square the divisor and seed the long division.
  // Value mode divides |x| * 2^15 by (256 + |x|); derivative mode divides 2^31
  // by (256 + |x|)^2. Both quotients fit in sixteen bits.
  assign dsq = mag_r.d * mag_r.d;

  always_comb begin
    setup_nxt.vld  = mag_r.vld;
    setup_nxt.mode = mag_r.mode;
    setup_nxt.neg  = mag_r.neg;
    setup_nxt.quo  = '0;
    if (mag_r.mode) begin
      setup_nxt.den    = dsq[ssa_pkg::DEN_W-1:0];
      setup_nxt.rem    = ssa_pkg::DERIV_REM_INIT;
      setup_nxt.num_lo = '0;
    end else begin
      setup_nxt.den    = ssa_pkg::DEN_W'(mag_r.d);
      setup_nxt.rem    = ssa_pkg::DEN_W'(mag_r.mag[ssa_pkg::MAG_W-1:1]);
      setup_nxt.num_lo = {mag_r.mag[0], {(ssa_pkg::RESULT_W-1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r.vld <= 1'b0;
    end else if (adv) begin
      setup_r <= setup_nxt;
    end
  end

  assign stage_o = setup_r;

endmodule

// ===== sv/ssa_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Softsign divider stage
// One restoring long-division step: shift in a numerator bit, trial subtract.
// ----------------------------------------------------------------------------
module ssa_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  ssa_pkg::ssa_div_t stage_i,
  output ssa_pkg::ssa_div_t stage_o
);

  ssa_pkg::ssa_div_t stage_r;
  ssa_pkg::ssa_div_t stage_nxt;

  logic [ssa_pkg::DEN_W:0]   part;
  logic [ssa_pkg::DEN_W+1:0] diff;
  logic                      ge;

  // The remainder stays below the divisor, so the shifted value needs one bit more.
  always_comb begin
    part = {stage_i.rem, stage_i.num_lo[ssa_pkg::RESULT_W-1]};
    diff = {1'b0, part} - {2'b00, stage_i.den};
    ge   = !diff[ssa_pkg::DEN_W+1];

    stage_nxt        = stage_i;
    stage_nxt.num_lo = {stage_i.num_lo[ssa_pkg::RESULT_W-2:0], 1'b0};
    stage_nxt.quo    = {stage_i.quo[ssa_pkg::RESULT_W-2:0], ge};
    if (ge) begin
      stage_nxt.rem = diff[ssa_pkg::DEN_W-1:0];
    end else begin
      stage_nxt.rem = part[ssa_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

// ===== sv/ssa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Softsign back end
// Applies the sign or the saturation and holds the output register.
// ----------------------------------------------------------------------------
module ssa_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  ssa_pkg::ssa_div_t            stage_i,
  output logic                         out_vld,
  output logic [ssa_pkg::RESULT_W-1:0] out_data
);

  logic                         vld_r;
  logic [ssa_pkg::RESULT_W-1:0] data_r;
  logic [ssa_pkg::RESULT_W-1:0] data_nxt;

  // The derivative at zero would be exactly one, so it is clipped to the maximum.
  always_comb begin
    if (stage_i.mode) begin
      data_nxt = (stage_i.quo > ssa_pkg::RES_MAX) ? ssa_pkg::RES_MAX : stage_i.quo;
    end else if (stage_i.neg) begin
      data_nxt = ssa_pkg::RESULT_W'(0) - stage_i.quo;
    end else begin
      data_nxt = stage_i.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= stage_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ===== sv/softsign_activation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Softsign activation top level
// Each sample passes the front end, the divider chain and the output register.
// Throughput: one sample per cycle; the divider has one stage per quotient bit.
// A stalled output freezes the whole pipeline, nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and selects value mode.
// ----------------------------------------------------------------------------
module softsign_activation_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [15:0] sample
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ssa_pkg::SAMPLE_W-1:0]   in_tdata,
  // out_tdata: [15:0] result
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ssa_pkg::RESULT_W-1:0]   out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ssa_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ssa_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  logic              mode;
  logic              adv;
  ssa_pkg::ssa_div_t chain [ssa_pkg::DIV_STEPS+1];

  // The pipeline moves whenever the output register is empty or being drained.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  ssa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mode        (mode)
  );

  ssa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_tvalid),
    .sample  (in_tdata),
    .mode    (mode),
    .stage_o (chain[0])
  );

  // Divider chain, most significant quotient bit first.
  for (genvar g = 0; g < ssa_pkg::DIV_STEPS; g++) begin : g_div
    ssa_div_stage u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  ssa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .stage_i  (chain[ssa_pkg::DIV_STEPS]),
    .out_vld  (out_tvalid),
    .out_data (out_tdata)
  );

  // A value-mode quotient is always below one, so its top bit must be clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    (chain[ssa_pkg::DIV_STEPS].vld && !chain[ssa_pkg::DIV_STEPS].mode)
      |-> !chain[ssa_pkg::DIV_STEPS].quo[ssa_pkg::RESULT_W-1])
    else $error("value-mode quotient reached one");

  // While the output stalls, the item in the middle divider stage must not change.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && chain[ssa_pkg::DIV_STEPS/2].vld)
      |=> $stable(chain[ssa_pkg::DIV_STEPS/2]))
    else $error("divider stage changed during a stall");

  // A derivative result is never negative.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && chain[ssa_pkg::DIV_STEPS].vld && chain[ssa_pkg::DIV_STEPS].mode)
      |=> !out_tdata[ssa_pkg::RESULT_W-1])
    else $error("derivative result has its sign bit set");

  // Straight after reset the output holds no transfer.
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Softsign activation testbench
// Streams Q8.8 samples through the softsign block in value and derivative
// mode and checks every Q1.15 result against a bit-exact predictor or a
// typed-in value. A short edge-case table comes first, then random phases
// with back-pressure, a long output hold-off and register writes in between.
// ----------------------------------------------------------------------------
module tb;

  localparam int  CLK_HALF     = 4;
  localparam int  RESET_CYCLES = 6;
  localparam int  HOLD_CYCLES  = 120;
  localparam int  TAIL_CYCLES  = 40;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  IDLE_PCT     = 28;

  localparam logic [ssa_pkg::CFG_ADDR_W-1:0] ADDR_MODE   = ssa_pkg::CFG_ADDR_W'(0);
  localparam logic [ssa_pkg::CFG_ADDR_W-1:0] ADDR_UNUSED = ssa_pkg::CFG_ADDR_W'(4);

  // One row of the directed table: register word in force, sample, and the
  // typed-in result where it is obvious.
  typedef struct packed {
    logic [ssa_pkg::CFG_DATA_W-1:0] mode_word;
    logic [ssa_pkg::SAMPLE_W-1:0]   sample;
    logic                           known;
    logic [ssa_pkg::RESULT_W-1:0]   result;
  } edge_row_t;

  localparam int EDGE_ROWS = 24;

  edge_row_t edge_tab [EDGE_ROWS] = '{
    // Value mode straight after reset.
    '{32'h0000_0000, 16'h0000, 1'b1, 16'h0000},
    '{32'h0000_0000, 16'h0001, 1'b0, 16'h0000},
    '{32'h0000_0000, 16'hFFFF, 1'b0, 16'h0000},
    '{32'h0000_0000, 16'h00FF, 1'b0, 16'h0000},
    '{32'h0000_0000, 16'h0100, 1'b1, 16'h4000},
    '{32'h0000_0000, 16'hFF00, 1'b1, 16'hC000},
    '{32'h0000_0000, 16'h7FFF, 1'b0, 16'h0000},
    '{32'h0000_0000, 16'h8000, 1'b0, 16'h0000},
    '{32'h0000_0000, 16'h8001, 1'b0, 16'h0000},
    '{32'h0000_0000, 16'h5555, 1'b0, 16'h0000},
    '{32'h0000_0000, 16'hAAAA, 1'b0, 16'h0000},
    // Derivative mode, saturation at zero and the smallest slopes.
    '{32'h0000_0001, 16'h0000, 1'b1, 16'h7FFF},
    '{32'h0000_0001, 16'h0001, 1'b0, 16'h0000},
    '{32'h0000_0001, 16'hFFFF, 1'b0, 16'h0000},
    '{32'h0000_0001, 16'h0100, 1'b1, 16'h2000},
    '{32'h0000_0001, 16'hFF00, 1'b1, 16'h2000},
    '{32'h0000_0001, 16'h7FFF, 1'b1, 16'h0001},
    '{32'h0000_0001, 16'h8000, 1'b1, 16'h0001},
    '{32'h0000_0001, 16'h5555, 1'b0, 16'h0000},
    '{32'h0000_0001, 16'hAAAA, 1'b0, 16'h0000},
    // Only bit 0 of the register word counts.
    '{32'hFFFF_FFFE, 16'h0080, 1'b0, 16'h0000},
    '{32'hFFFF_FFFE, 16'hFF80, 1'b0, 16'h0000},
    '{32'hFFFF_FFFF, 16'h0080, 1'b0, 16'h0000},
    '{32'hFFFF_FFFF, 16'h8000, 1'b1, 16'h0001}
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [ssa_pkg::SAMPLE_W-1:0]   in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [ssa_pkg::RESULT_W-1:0]   out_tdata;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [ssa_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  // Shadow of the mode register and the results still owed by the block.
  logic                           mode_now = 1'b0;
  logic [ssa_pkg::RESULT_W-1:0]   owed_results [$];

  int  error_count   = 0;
  int  results_seen  = 0;
  int  value_samples = 0;
  int  slope_samples = 0;
  int  cycle_count   = 0;
  bit  tx_idle_on    = 1'b0;
  bit  rx_idle_on    = 1'b0;
  bit  hold_go       = 1'b0;
  bit  hold_taken    = 1'b0;

  softsign_activation_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // Softsign value x/(1+|x|) or slope 1/(1+|x|)^2 in Q1.15 from a Q8.8 sample.
  function automatic logic [ssa_pkg::RESULT_W-1:0] softsign_expect(
    input logic                         slope,
    input logic [ssa_pkg::SAMPLE_W-1:0] x
  );
    logic [ssa_pkg::MAG_W-1:0] mag;
    logic [63:0]               den;
    logic [63:0]               q;
    mag = x[ssa_pkg::SAMPLE_W-1] ? (ssa_pkg::MAG_W'(17'h1_0000) - {1'b0, x})
                                 : {1'b0, x};
    den = 64'(mag) + 64'd256;
    if (slope) begin
      q = (64'd1 << 31) / (den * den);
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
    end else begin
      q = (64'(mag) << 15) / den;
      if (x[ssa_pkg::SAMPLE_W-1]) begin
        q = -q;
      end
    end
    return q[ssa_pkg::RESULT_W-1:0];
  endfunction

  // Random samples weighted towards small magnitudes and the range ends.
  function automatic logic [ssa_pkg::SAMPLE_W-1:0] pick_sample();
    logic [ssa_pkg::SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      5, 6: begin
        s = ssa_pkg::SAMPLE_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 1) == 1) begin
          s = -s;
        end
      end
      7: begin
        s = 16'h8000 + ssa_pkg::SAMPLE_W'($urandom_range(0, 3));
      end
      8: begin
        s = 16'h7FFF - ssa_pkg::SAMPLE_W'($urandom_range(0, 3));
      end
      9: begin
        s = {8'($urandom_range(0, 255)), 8'h00};
      end
      default: begin
        s = ssa_pkg::SAMPLE_W'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Offer one sample and wait for its transfer; the expectation is queued then.
  task automatic send_sample(input logic [ssa_pkg::SAMPLE_W-1:0] s, input logic known,
                             input logic [ssa_pkg::RESULT_W-1:0] typed);
    while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    owed_results.insert(owed_results.size(), known ? typed : softsign_expect(mode_now, s));
    if (mode_now) begin
      slope_samples++;
    end else begin
      value_samples++;
    end
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (owed_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic cfg_access(input logic wr, input logic [ssa_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [ssa_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) begin
      @(posedge clk);
    end
    if (wr && addr[2] == ssa_pkg::REG_IDX_MODE) begin
      mode_now = data[0];
    end
    if (!wr && cfg_prdata != {{(ssa_pkg::CFG_DATA_W-1){1'b0}}, mode_now}) begin
      report_mismatch($sformatf("mode register read %h, expected %0d", cfg_prdata,
                                mode_now));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Write a register word while idle and read the mode back.
  task automatic set_mode(input logic [ssa_pkg::CFG_ADDR_W-1:0] addr,
                          input logic [ssa_pkg::CFG_DATA_W-1:0] word);
    drain();
    cfg_access(1'b1, addr, word);
    cfg_access(1'b0, ADDR_MODE, '0);
  endtask

  task automatic random_phase(input int count, input bit tx_idle, input bit rx_idle);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    for (int i = 0; i < count; i++) begin
      send_sample(pick_sample(), 1'b0, '0);
    end
  endtask

  // Result checking: each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  $signed(out_tdata)));
      end else begin
        if (out_tdata !== owed_results[0]) begin
          report_mismatch($sformatf("result %0d, expected %0d", $signed(out_tdata),
                                    $signed(owed_results[0])));
        end
        void'(owed_results.pop_front());
      end
      results_seen++;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= rst_n && !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results owed", cycle_count,
               owed_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    logic [ssa_pkg::CFG_DATA_W-1:0] word_now;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The mode register must read as value mode after reset.
    cfg_access(1'b0, ADDR_MODE, '0);

    // Directed table, with both sides idling at random.
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    word_now   = '0;
    for (int i = 0; i < EDGE_ROWS; i++) begin
      if (edge_tab[i].mode_word != word_now) begin
        word_now = edge_tab[i].mode_word;
        set_mode(ADDR_MODE, word_now);
      end
      send_sample(edge_tab[i].sample, edge_tab[i].known, edge_tab[i].result);
    end

    // A write to an address with no register leaves derivative mode in place.
    set_mode(ADDR_UNUSED, 32'h0000_0000);
    random_phase(100, 1'b1, 1'b1);

    set_mode(ADDR_MODE, 32'h0000_0000);
    random_phase(150, 1'b1, 1'b1);

    // Long output hold-off while the sender keeps offering samples.
    set_mode(ADDR_MODE, 32'h0000_0001);
    hold_go = 1'b1;
    random_phase(100, 1'b0, 1'b1);

    // Full rate on both sides.
    set_mode(ADDR_MODE, 32'hA5A5_A5A4);
    random_phase(150, 1'b0, 1'b0);

    set_mode(ADDR_MODE, 32'h5A5A_5A5B);
    random_phase(120, 1'b1, 1'b1);

    // Back to value mode, with a full pause of the sender half-way.
    set_mode(ADDR_MODE, 32'h0000_0000);
    random_phase(65, 1'b1, 1'b1);
    drain();
    random_phase(65, 1'b1, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d value-mode and %0d derivative-mode samples, %0d results checked,",
             value_samples, slope_samples, results_seen);
    $display("with random stalls on both sides and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== softsign_activation_top.f =====
sv/ssa_pkg.sv
sv/ssa_cfg.sv
sv/ssa_front.sv
sv/ssa_div_stage.sv
sv/ssa_back.sv
sv/softsign_activation_top.sv
sim/tb.sv
